// ===== sv/stok_pkg.sv =====
// stok_pkg: shared types, token kind codes and helper functions for the source tokenizer
// depends on nothing; imported by every module of the tokenizer
package stok_pkg;

   localparam int COUNTER_BITS      = 16;
   localparam int KEYWORD_MAX_CHARS = 5;
   localparam int WIN_BITS          = 8 * KEYWORD_MAX_CHARS;
   localparam int FIELD_BITS        = 16;
   localparam int KIND_BITS         = 5;
   localparam int MAX_TOKENS        = 3;
   localparam int TCNT_BITS         = $clog2(MAX_TOKENS + 1);
   localparam int TIDX_BITS         = $clog2(MAX_TOKENS);
   localparam int QUEUE_DEPTH       = 4;
   localparam int QPTR_BITS         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS         = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};
   localparam logic [COUNTER_BITS-1:0] CNT_ONE = COUNTER_BITS'(1);

   typedef logic [KIND_BITS-1:0] kind_type;

   localparam kind_type TK_NUM    = 5'd0;
   localparam kind_type TK_IDENT  = 5'd1;
   localparam kind_type TK_PRINT  = 5'd2;
   localparam kind_type TK_IF     = 5'd3;
   localparam kind_type TK_ELSE   = 5'd4;
   localparam kind_type TK_WHILE  = 5'd5;
   localparam kind_type TK_ASSIGN = 5'd6;
   localparam kind_type TK_EQ     = 5'd7;
   localparam kind_type TK_PLUS   = 5'd8;
   localparam kind_type TK_MINUS  = 5'd9;
   localparam kind_type TK_STAR   = 5'd10;
   localparam kind_type TK_DIV    = 5'd11;
   localparam kind_type TK_LPAREN = 5'd12;
   localparam kind_type TK_RPAREN = 5'd13;
   localparam kind_type TK_SEMI   = 5'd14;
   localparam kind_type TK_LBRACE = 5'd15;
   localparam kind_type TK_RBRACE = 5'd16;
   localparam kind_type TK_LT     = 5'd17;
   localparam kind_type TK_GT     = 5'd18;
   localparam kind_type TK_ERROR  = 5'd19;
   localparam kind_type TK_EOF    = 5'd20;

   // keywords right-aligned in the window, upper bytes zero
   localparam logic [WIN_BITS-1:0] KW_PRINT = "print";
   localparam logic [WIN_BITS-1:0] KW_IF    = "if";
   localparam logic [WIN_BITS-1:0] KW_ELSE  = "else";
   localparam logic [WIN_BITS-1:0] KW_WHILE = "while";

   typedef struct packed {
      kind_type              kind;
      logic [FIELD_BITS-1:0] line;
      logic [FIELD_BITS-1:0] column;
      logic [FIELD_BITS-1:0] offset;
      logic [FIELD_BITS-1:0] length;
   } token_type;

   // all tokens caused by one source byte
   typedef struct packed {
      logic [TCNT_BITS-1:0]              count;
      token_type [MAX_TOKENS-1:0]        tok;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] x);
      return (x == CNT_MAX) ? x : x + CNT_ONE;
   endfunction

   function automatic logic [COUNTER_BITS-1:0] run_length(
      input logic [COUNTER_BITS-1:0] pos,
      input logic [COUNTER_BITS-1:0] start);
      return (pos >= start) ? pos - start : '0;
   endfunction

   function automatic kind_type ident_kind(input logic [WIN_BITS-1:0] win,
                                           input logic [COUNTER_BITS-1:0] len);
      kind_type k;
      k = TK_IDENT;
      if (len == COUNTER_BITS'(5) && win == KW_PRINT) begin
         k = TK_PRINT;
      end else if (len == COUNTER_BITS'(2) && win == KW_IF) begin
         k = TK_IF;
      end else if (len == COUNTER_BITS'(4) && win == KW_ELSE) begin
         k = TK_ELSE;
      end else if (len == COUNTER_BITS'(5) && win == KW_WHILE) begin
         k = TK_WHILE;
      end
      return k;
   endfunction

   function automatic token_type make_tok(input kind_type k,
                                          input logic [COUNTER_BITS-1:0] line,
                                          input logic [COUNTER_BITS-1:0] column,
                                          input logic [COUNTER_BITS-1:0] offset,
                                          input logic [COUNTER_BITS-1:0] length);
      token_type t;
      t.kind   = k;
      t.line   = FIELD_BITS'(line);
      t.column = FIELD_BITS'(column);
      t.offset = FIELD_BITS'(offset);
      t.length = FIELD_BITS'(length);
      return t;
   endfunction

endpackage

// ===== sv/source_tokenizer_unit.sv =====
// source_tokenizer_unit: top level of the streaming source tokenizer
// depends on stok_pkg, stok_front, stok_queue, stok_back
//
// The tokenizer takes one source byte per transfer and returns the tokens that byte
// completes, each with kind, start line, start column, byte offset and length; the last
// token caused by a byte carries rsp_last_of_run. A byte can cause zero to three tokens
// (whitespace and comment bytes add no token of their own; a byte flagged req_end_of_text
// flushes any pending token and adds an eof token, then the line, column and offset
// counters restart at line 1, column 1, offset 0). The input side takes one byte per
// cycle while the four-entry bundle queue has room; the output side delivers one token
// per cycle from its output register while rsp_stall is low, so a byte that causes
// several tokens occupies the result side for one transfer per token. Bytes that cause
// no token use the input side only. Counters saturate at 65535.
module source_tokenizer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_char_byte,
   input  logic        req_end_of_text,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_token_kind,
   output logic [15:0] rsp_start_line,
   output logic [15:0] rsp_start_column,
   output logic [15:0] rsp_start_offset,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last_of_run
);
   import stok_pkg::*;

   // scanner -> queue
   logic          push;
   bundle_type    push_bundle;
   // queue -> serializer
   bundle_type    head_bundle;
   q_status_type  q_status;
   logic          pop;

   // front: classifies each byte and builds its token bundle
   stok_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_char_byte   (req_char_byte),
      .req_end_of_text (req_end_of_text),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .q_status        (q_status),
      .push            (push),
      .push_bundle     (push_bundle)
   );

   // decouples scanning from token delivery
   stok_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .head_bundle (head_bundle),
      .q_status    (q_status)
   );

   // back: one token per transfer out of the head bundle
   stok_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_bundle      (head_bundle),
      .q_status         (q_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_start_line   (rsp_start_line),
      .rsp_start_column (rsp_start_column),
      .rsp_start_offset (rsp_start_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

`ifndef SYNTHESIS
   // the scanner never writes a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full))
      else $error("bundle pushed into full queue");

   // a last byte always yields a bundle with eof
   a_eot_pushes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_end_of_text) |-> push)
      else $error("end of text without token bundle");

   // finishing a bundle leaves its last token in the output register
   a_pop_shows: assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_valid && rsp_last_of_run))
      else $error("bundle popped without output");

   // eof closes its run and has no length
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_token_kind == TK_EOF) |-> (rsp_last_of_run && rsp_token_length == '0))
      else $error("eof token not last of run");
`endif

endmodule

// ===== sv/stok_front.sv =====
// stok_front: byte scanner; keeps the scan mode and position counters and builds the
// bundle of tokens each byte completes. depends on stok_pkg
module stok_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              req_char_byte,
   input  logic                    req_end_of_text,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  stok_pkg::q_status_type  q_status,
   output logic                    push,
   output stok_pkg::bundle_type    push_bundle
);
   import stok_pkg::*;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_NUM,
      MODE_IDENT,
      MODE_EQ,
      MODE_SLASH,
      MODE_COMMENT
   } mode_type;

   localparam logic [7:0] CH_NL    = 8'd10;
   localparam logic [7:0] CH_EQ    = "=";
   localparam logic [7:0] CH_SLASH = "/";

   mode_type                  mode_ff, mode_in;
   logic [COUNTER_BITS-1:0]   line_ff, line_in;
   logic [COUNTER_BITS-1:0]   col_ff, col_in;
   logic [COUNTER_BITS-1:0]   pos_ff, pos_in;
   logic [COUNTER_BITS-1:0]   pst_off_ff, pst_off_in;
   logic [COUNTER_BITS-1:0]   pst_line_ff, pst_line_in;
   logic [COUNTER_BITS-1:0]   pst_col_ff, pst_col_in;
   logic [WIN_BITS-1:0]       win_ff, win_in;

   bundle_type                bnd;
   logic [TCNT_BITS-1:0]      n_v;
   logic                      consumed;
   logic                      accept;
   logic                      is_dig, is_alpha, is_space, is_word;

   function automatic kind_type single_kind(input logic [7:0] b);
      kind_type k;
      case (b)
         "+":     k = TK_PLUS;
         "-":     k = TK_MINUS;
         "*":     k = TK_STAR;
         "(":     k = TK_LPAREN;
         ")":     k = TK_RPAREN;
         ";":     k = TK_SEMI;
         "{":     k = TK_LBRACE;
         "}":     k = TK_RBRACE;
         "<":     k = TK_LT;
         ">":     k = TK_GT;
         default: k = TK_ERROR;
      endcase
      return k;
   endfunction

   assign is_dig   = (req_char_byte >= "0") && (req_char_byte <= "9");
   assign is_alpha = ((req_char_byte >= "a") && (req_char_byte <= "z")) ||
                     ((req_char_byte >= "A") && (req_char_byte <= "Z"));
   assign is_space = (req_char_byte == " ") ||
                     ((req_char_byte >= 8'd9) && (req_char_byte <= 8'd13));
   assign is_word  = is_alpha || is_dig || (req_char_byte == "_");

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   always_comb begin
      mode_in     = mode_ff;
      line_in     = line_ff;
      col_in      = col_ff;
      pos_in      = pos_ff;
      pst_off_in  = pst_off_ff;
      pst_line_in = pst_line_ff;
      pst_col_in  = pst_col_ff;
      win_in      = win_ff;
      bnd         = '0;
      n_v         = '0;
      consumed    = 1'b0;

      // pending token continues or closes
      case (mode_ff)
         MODE_NUM: begin
            if (is_dig) begin
               col_in   = sat_inc(col_ff);
               pos_in   = sat_inc(pos_ff);
               consumed = 1'b1;
            end else begin
               bnd.tok[n_v[TIDX_BITS-1:0]] = make_tok(TK_NUM, pst_line_ff, pst_col_ff,
                  pst_off_ff, run_length(pos_ff, pst_off_ff));
               n_v     = n_v + TCNT_BITS'(1);
               mode_in = MODE_IDLE;
            end
         end
         MODE_IDENT: begin
            if (is_word) begin
               win_in   = {win_ff[WIN_BITS-9:0], req_char_byte};
               col_in   = sat_inc(col_ff);
               pos_in   = sat_inc(pos_ff);
               consumed = 1'b1;
            end else begin
               bnd.tok[n_v[TIDX_BITS-1:0]] = make_tok(
                  ident_kind(win_ff, run_length(pos_ff, pst_off_ff)),
                  pst_line_ff, pst_col_ff, pst_off_ff, run_length(pos_ff, pst_off_ff));
               n_v     = n_v + TCNT_BITS'(1);
               mode_in = MODE_IDLE;
            end
         end
         MODE_EQ: begin
            mode_in = MODE_IDLE;
            if (req_char_byte == CH_EQ) begin
               bnd.tok[n_v[TIDX_BITS-1:0]] = make_tok(TK_EQ, pst_line_ff, pst_col_ff,
                  pst_off_ff, COUNTER_BITS'(2));
               n_v      = n_v + TCNT_BITS'(1);
               col_in   = sat_inc(col_ff);
               pos_in   = sat_inc(pos_ff);
               consumed = 1'b1;
            end else begin
               bnd.tok[n_v[TIDX_BITS-1:0]] = make_tok(TK_ASSIGN, pst_line_ff, pst_col_ff,
                  pst_off_ff, CNT_ONE);
               n_v = n_v + TCNT_BITS'(1);
            end
         end
         MODE_SLASH: begin
            if (req_char_byte == CH_SLASH) begin
               // comment bytes do not move the column
               col_in   = pst_col_ff;
               pos_in   = sat_inc(pos_ff);
               mode_in  = MODE_COMMENT;
               consumed = 1'b1;
            end else begin
               bnd.tok[n_v[TIDX_BITS-1:0]] = make_tok(TK_DIV, pst_line_ff, pst_col_ff,
                  pst_off_ff, CNT_ONE);
               n_v     = n_v + TCNT_BITS'(1);
               mode_in = MODE_IDLE;
            end
         end
         MODE_COMMENT: begin
            if (req_char_byte != CH_NL) begin
               pos_in   = sat_inc(pos_ff);
               consumed = 1'b1;
            end else begin
               mode_in = MODE_IDLE;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase

      // byte seen from idle
      if (!consumed) begin
         if (is_space) begin
            if (req_char_byte == CH_NL) begin
               line_in = sat_inc(line_in);
               col_in  = CNT_ONE;
            end else begin
               col_in = sat_inc(col_in);
            end
            pos_in = sat_inc(pos_in);
         end else if (is_dig || is_alpha || req_char_byte == "_" ||
                      req_char_byte == CH_EQ || req_char_byte == CH_SLASH) begin
            pst_off_in  = pos_in;
            pst_line_in = line_in;
            pst_col_in  = col_in;
            if (is_dig) begin
               mode_in = MODE_NUM;
            end else if (req_char_byte == CH_EQ) begin
               mode_in = MODE_EQ;
            end else if (req_char_byte == CH_SLASH) begin
               mode_in = MODE_SLASH;
            end else begin
               win_in  = WIN_BITS'(req_char_byte);
               mode_in = MODE_IDENT;
            end
            col_in = sat_inc(col_in);
            pos_in = sat_inc(pos_in);
         end else begin
            bnd.tok[n_v[TIDX_BITS-1:0]] = make_tok(single_kind(req_char_byte), line_in,
               col_in, pos_in, CNT_ONE);
            n_v     = n_v + TCNT_BITS'(1);
            col_in  = sat_inc(col_in);
            pos_in  = sat_inc(pos_in);
            mode_in = MODE_IDLE;
         end
      end

      // end of text: flush, eof, restart counters
      if (req_end_of_text) begin
         case (mode_in)
            MODE_NUM: begin
               bnd.tok[n_v[TIDX_BITS-1:0]] = make_tok(TK_NUM, pst_line_in, pst_col_in,
                  pst_off_in, run_length(pos_in, pst_off_in));
               n_v = n_v + TCNT_BITS'(1);
            end
            MODE_IDENT: begin
               bnd.tok[n_v[TIDX_BITS-1:0]] = make_tok(
                  ident_kind(win_in, run_length(pos_in, pst_off_in)),
                  pst_line_in, pst_col_in, pst_off_in, run_length(pos_in, pst_off_in));
               n_v = n_v + TCNT_BITS'(1);
            end
            MODE_EQ: begin
               bnd.tok[n_v[TIDX_BITS-1:0]] = make_tok(TK_ASSIGN, pst_line_in, pst_col_in,
                  pst_off_in, CNT_ONE);
               n_v = n_v + TCNT_BITS'(1);
            end
            MODE_SLASH: begin
               bnd.tok[n_v[TIDX_BITS-1:0]] = make_tok(TK_DIV, pst_line_in, pst_col_in,
                  pst_off_in, CNT_ONE);
               n_v = n_v + TCNT_BITS'(1);
            end
            default: begin
            end
         endcase
         bnd.tok[n_v[TIDX_BITS-1:0]] = make_tok(TK_EOF, line_in, col_in, pos_in, '0);
         n_v         = n_v + TCNT_BITS'(1);
         mode_in     = MODE_IDLE;
         line_in     = CNT_ONE;
         col_in      = CNT_ONE;
         pos_in      = '0;
         pst_off_in  = '0;
         pst_line_in = CNT_ONE;
         pst_col_in  = CNT_ONE;
         win_in      = '0;
      end

      bnd.count = n_v;
   end

   assign push        = accept && (n_v != '0);
   assign push_bundle = bnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         line_ff     <= CNT_ONE;
         col_ff      <= CNT_ONE;
         pos_ff      <= '0;
         pst_off_ff  <= '0;
         pst_line_ff <= CNT_ONE;
         pst_col_ff  <= CNT_ONE;
         win_ff      <= '0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         line_ff     <= line_in;
         col_ff      <= col_in;
         pos_ff      <= pos_in;
         pst_off_ff  <= pst_off_in;
         pst_line_ff <= pst_line_in;
         pst_col_ff  <= pst_col_in;
         win_ff      <= win_in;
      end
   end

endmodule

// ===== sv/stok_queue.sv =====
// stok_queue: small fifo of token bundles between scanner and serializer
// depends on stok_pkg
module stok_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  stok_pkg::bundle_type    push_bundle,
   input  logic                    pop,
   output stok_pkg::bundle_type    head_bundle,
   output stok_pkg::q_status_type  q_status
);
   import stok_pkg::*;

   bundle_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]    head_ff, head_in;
   logic [QPTR_BITS-1:0]    tail_ff, tail_in;
   logic [QCNT_BITS-1:0]    count_ff, count_in;
   logic                    do_push, do_pop;

   function automatic logic [QPTR_BITS-1:0] next_ptr(input logic [QPTR_BITS-1:0] p);
      return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
   endfunction

   assign q_status.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push = push && !q_status.full;
   assign do_pop  = pop && !q_status.empty;
   assign head_bundle = entry_ff[head_ff];

   always_comb begin
      head_in  = do_pop  ? next_ptr(head_ff) : head_ff;
      tail_in  = do_push ? next_ptr(tail_ff) : tail_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[tail_ff] <= push_bundle;
      end
   end

endmodule

// ===== sv/stok_back.sv =====
// stok_back: serializer; walks the head bundle one token per cycle, while the output is
// not stalled, into the output register. depends on stok_pkg
module stok_back (
   input  logic                    clock,
   input  logic                    reset,
   input  stok_pkg::bundle_type    head_bundle,
   input  stok_pkg::q_status_type  q_status,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [4:0]              rsp_token_kind,
   output logic [15:0]             rsp_start_line,
   output logic [15:0]             rsp_start_column,
   output logic [15:0]             rsp_start_offset,
   output logic [15:0]             rsp_token_length,
   output logic                    rsp_last_of_run
);
   import stok_pkg::*;

   logic [TIDX_BITS-1:0]  idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   token_type             tok_ff;
   logic                  last_ff;
   logic                  load, at_last;
   token_type             cur_tok;

   assign load    = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign at_last = (TCNT_BITS'(idx_ff) + TCNT_BITS'(1)) == head_bundle.count;
   assign cur_tok = head_bundle.tok[idx_ff];
   assign pop     = load && at_last;

   always_comb begin
      idx_in = idx_ff;
      if (load) begin
         idx_in = at_last ? '0 : idx_ff + TIDX_BITS'(1);
      end
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff  <= cur_tok;
         last_ff <= at_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_token_kind   = tok_ff.kind;
   assign rsp_start_line   = tok_ff.line;
   assign rsp_start_column = tok_ff.column;
   assign rsp_start_offset = tok_ff.offset;
   assign rsp_token_length = tok_ff.length;
   assign rsp_last_of_run  = last_ff;

endmodule

// ===== dv/source_tokenizer_unit_tb.sv =====
`timescale 1ns / 100ps
// source_tokenizer_unit_tb: self-checking testbench for the streaming source tokenizer
// needs stok_pkg and source_tokenizer_unit; predicts every token and checks each rsp transfer
module source_tokenizer_unit_tb;
   import stok_pkg::*;

   // random part tops the directed bytes up to about 480 transfers in all
   localparam int unsigned RANDOM_ITEMS    = 340;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned DRAIN_CYCLES    = 50;
   localparam int unsigned CYCLE_LIMIT     = 2_000_000;

   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_CR      = 8'd13;
   localparam logic [7:0] CH_SPACE   = 8'd32;

   // keywords right-aligned in the 5-byte tail of the current word
   localparam logic [39:0] WORD_PRINT = "print";
   localparam logic [39:0] WORD_IF    = "if";
   localparam logic [39:0] WORD_ELSE  = "else";
   localparam logic [39:0] WORD_WHILE = "while";

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_NUMBER, SCAN_WORD, SCAN_EQUALS, SCAN_SLASH, SCAN_COMMENT
   } scan_state_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] line;
      logic [15:0] column;
      logic [15:0] offset;
      logic [15:0] length;
      logic        last_one;
   } token_rec_type;

   // every input is known from time zero; reset is high until the sequence drops it
   logic        clock;
   logic        reset           = 1'b1;
   logic [7:0]  req_char_byte   = 8'd0;
   logic        req_end_of_text = 1'b0;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [4:0]  rsp_token_kind;
   logic [15:0] rsp_start_line;
   logic [15:0] rsp_start_column;
   logic [15:0] rsp_start_offset;
   logic [15:0] rsp_token_length;
   logic        rsp_last_of_run;

   source_tokenizer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_char_byte    (req_char_byte),
      .req_end_of_text  (req_end_of_text),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_start_line   (rsp_start_line),
      .rsp_start_column (rsp_start_column),
      .rsp_start_offset (rsp_start_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // tokens predicted but not yet seen on the rsp side, oldest first
   token_rec_type  expected_tokens[$];
   // newest token of the byte being predicted, held back until its last flag is known
   token_rec_type  held_token;
   bit             have_held;

   // scanner image: mode, running position and the start of the open token
   scan_state_type scan;
   logic [15:0] line_no;
   logic [15:0] col_no;
   logic [15:0] text_pos;
   logic [15:0] tok_off;
   logic [15:0] tok_line;
   logic [15:0] tok_col;
   logic [39:0] word_tail;

   int unsigned error_count   = 0;
   int unsigned cycle_count   = 0;
   int unsigned counted_bytes = 0;
   bit          sender_gaps_on     = 1'b1;
   bit          receiver_stalls_on = 1'b1;
   bit          hold_off_request   = 1'b0;

   string keywords[4] = '{"print", "if", "else", "while"};
   string word_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   string blank_chars = " \t\n\013\014\015";
   string op_chars    = "+-*/(){};<>=";

   // ---------------------------------------------------------------------------
   // token predictor
   // ---------------------------------------------------------------------------

   function automatic logic [15:0] sat_bump(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic bit is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic bit is_alpha(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   endfunction

   function automatic bit is_blank(input logic [7:0] b);
      return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
   endfunction

   function automatic void restart_text();
      scan      = SCAN_IDLE;
      line_no   = 16'd1;
      col_no    = 16'd1;
      text_pos  = 16'd0;
      tok_off   = 16'd0;
      tok_line  = 16'd1;
      tok_col   = 16'd1;
      word_tail = '0;
   endfunction

   function automatic void add_token(input kind_type k, input logic [15:0] ln, cl, ofs, len);
      if (have_held) begin
         expected_tokens.push_back(held_token);
      end
      held_token = '{k, ln, cl, ofs, len, 1'b0};
      have_held  = 1'b1;
   endfunction

   // length of a number or word; undercounts once the position has saturated
   function automatic logic [15:0] span_len();
      return (text_pos >= tok_off) ? text_pos - tok_off : 16'd0;
   endfunction

   function automatic kind_type word_kind(input logic [15:0] len);
      if (len == 16'd5 && word_tail == WORD_PRINT) return TK_PRINT;
      if (len == 16'd2 && word_tail == WORD_IF)    return TK_IF;
      if (len == 16'd4 && word_tail == WORD_ELSE)  return TK_ELSE;
      if (len == 16'd5 && word_tail == WORD_WHILE) return TK_WHILE;
      return TK_IDENT;
   endfunction

   // emit whatever token is still open; a comment gives nothing
   function automatic void close_pending();
      case (scan)
         SCAN_NUMBER: add_token(TK_NUM, tok_line, tok_col, tok_off, span_len());
         SCAN_WORD:   add_token(word_kind(span_len()), tok_line, tok_col, tok_off, span_len());
         SCAN_EQUALS: add_token(TK_ASSIGN, tok_line, tok_col, tok_off, 16'd1);
         SCAN_SLASH:  add_token(TK_DIV, tok_line, tok_col, tok_off, 16'd1);
         default: ;
      endcase
   endfunction

   function automatic void open_token(input scan_state_type mode);
      tok_off  = text_pos;
      tok_line = line_no;
      tok_col  = col_no;
      scan     = mode;
      col_no   = sat_bump(col_no);
      text_pos = sat_bump(text_pos);
   endfunction

   // one accepted byte: extend the open token or close it and scan the byte afresh
   function automatic void predict_byte(input logic [7:0] b, input logic eot);
      bit       grows;
      kind_type k;
      case (scan)
         SCAN_NUMBER:  grows = is_digit(b);
         SCAN_WORD:    grows = is_alpha(b) || is_digit(b);
         SCAN_EQUALS:  grows = (b == "=");
         SCAN_SLASH:   grows = (b == "/");
         SCAN_COMMENT: grows = (b != CH_NEWLINE);
         default:      grows = 1'b0;
      endcase
      if (grows) begin
         case (scan)
            SCAN_NUMBER: col_no = sat_bump(col_no);
            SCAN_WORD: begin
               word_tail = {word_tail[31:0], b};
               col_no    = sat_bump(col_no);
            end
            SCAN_EQUALS: begin
               add_token(TK_EQ, tok_line, tok_col, tok_off, 16'd2);
               col_no = sat_bump(col_no);
               scan   = SCAN_IDLE;
            end
            // comment bytes, both slashes included, take no columns
            SCAN_SLASH: begin
               col_no = tok_col;
               scan   = SCAN_COMMENT;
            end
            default: ;
         endcase
         text_pos = sat_bump(text_pos);
      end else begin
         close_pending();
         scan = SCAN_IDLE;
         if (is_blank(b)) begin
            if (b == CH_NEWLINE) begin
               line_no = sat_bump(line_no);
               col_no  = 16'd1;
            end else begin
               col_no = sat_bump(col_no);
            end
            text_pos = sat_bump(text_pos);
         end else if (is_digit(b)) begin
            open_token(SCAN_NUMBER);
         end else if (is_alpha(b)) begin
            word_tail = {32'd0, b};
            open_token(SCAN_WORD);
         end else if (b == "=") begin
            open_token(SCAN_EQUALS);
         end else if (b == "/") begin
            open_token(SCAN_SLASH);
         end else begin
            case (b)
               "+": k = TK_PLUS;
               "-": k = TK_MINUS;
               "*": k = TK_STAR;
               "(": k = TK_LPAREN;
               ")": k = TK_RPAREN;
               ";": k = TK_SEMI;
               "{": k = TK_LBRACE;
               "}": k = TK_RBRACE;
               "<": k = TK_LT;
               ">": k = TK_GT;
               default: k = TK_ERROR;
            endcase
            add_token(k, line_no, col_no, text_pos, 16'd1);
            col_no   = sat_bump(col_no);
            text_pos = sat_bump(text_pos);
         end
      end
      // last byte of a text: flush, eof at the position after the byte, counters restart
      if (eot) begin
         close_pending();
         add_token(TK_EOF, line_no, col_no, text_pos, 16'd0);
         restart_text();
      end
      if (have_held) begin
         held_token.last_one = 1'b1;
         expected_tokens.push_back(held_token);
         have_held = 1'b0;
      end
   endfunction

   // ---------------------------------------------------------------------------
   // req side: one byte per transfer, inputs move on the falling edge
   // ---------------------------------------------------------------------------

   // mostly short gaps, now and then a long one
   function automatic int unsigned idle_length();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
   endfunction

   // valid stays high from one transfer to the next unless a gap is inserted
   task automatic send_byte(input logic [7:0] b, input logic eot);
      int unsigned gap;
      gap = 0;
      if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
         gap = idle_length();
      end
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_char_byte   <= b;
      req_end_of_text <= eot;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      // transfer taken at this edge
      predict_byte(b, eot);
      counted_bytes++;
   endtask

   task automatic send_text(input string text, input bit eot_last);
      for (int i = 0; i < text.len(); i++) begin
         send_byte(text[i], eot_last && (i == text.len() - 1));
      end
   endtask

   // random byte of the random part; about one byte in forty ends its text
   task automatic send_rand(input logic [7:0] b);
      send_byte(b, $urandom_range(0, 39) == 0);
   endtask

   // one lexical fragment: mostly well-formed pieces, some noise
   task automatic send_fragment();
      string       kw;
      logic [7:0]  op;
      case ($urandom_range(0, 11))
         0, 1: begin
            kw = keywords[$urandom_range(0, 3)];
            for (int i = 0; i < kw.len(); i++) begin
               send_rand(kw[i]);
            end
            // sometimes a keyword grows into a plain word
            if ($urandom_range(0, 3) == 0) begin
               send_rand(word_chars[$urandom_range(0, word_chars.len() - 1)]);
            end
         end
         2, 3: begin
            send_rand(word_chars[$urandom_range(0, 52)]);
            repeat ($urandom_range(0, 6)) send_rand(word_chars[$urandom_range(0, 62)]);
         end
         4: repeat ($urandom_range(1, 5)) send_rand(8'("0" + $urandom_range(0, 9)));
         5, 6: begin
            op = op_chars[$urandom_range(0, op_chars.len() - 1)];
            send_rand(op);
            if (op == "=" && $urandom_range(0, 1) == 0) begin
               send_rand("=");
            end
         end
         7, 8, 9: send_rand(blank_chars[$urandom_range(0, blank_chars.len() - 1)]);
         10: begin
            send_rand("/");
            send_rand("/");
            repeat ($urandom_range(0, 8)) send_rand(8'($urandom_range(32, 126)));
            send_rand(CH_NEWLINE);
         end
         default: send_rand(8'($urandom_range(0, 255)));
      endcase
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // rsp side: random stall runs, plus one long hold-off on request
   // ---------------------------------------------------------------------------

   initial begin : receiver_stall
      int unsigned run;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else if (receiver_stalls_on && $urandom_range(0, 2) == 0) begin
            run = idle_length();
            rsp_stall <= 1'b1;
            repeat (run - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic void check_field(input string field, input logic [15:0] want, got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
         error_count++;
      end
   endfunction

   // every rsp transfer is matched against the oldest predicted token
   always @(posedge clock) begin : token_checker
      token_rec_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected token, expected none actual kind %0d", $time,
                     rsp_token_kind);
            error_count++;
         end else begin
            want = expected_tokens.pop_front();
            check_field("token_kind", 16'(want.kind), 16'(rsp_token_kind));
            check_field("start_line", want.line, rsp_start_line);
            check_field("start_column", want.column, rsp_start_column);
            check_field("start_offset", want.offset, rsp_start_offset);
            check_field("token_length", want.length, rsp_token_length);
            check_field("last_of_run", 16'(want.last_one), 16'(rsp_last_of_run));
         end
      end
   end

   // watchdog against a hang anywhere in the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("source_tokenizer_unit_tb: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // keywords, a word with an underscore, a number closed by the end of text
   task automatic test_keywords();
      send_text("print if else while _9 07", 1'b1);
   endtask

   // '==' against '=', a lone slash, a comment to end of line, every operator;
   // the final ';' closes a word, gives its own token and eof in one transfer
   task automatic test_operators();
      send_text("a==b=c/d//x\n+-*(){}<>x;", 1'b1);
   endtask

   // error bytes at both ends of the range, every whitespace byte but newline, pending tokens at end of text
   task automatic test_odd_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text("@\t\013\014\015 =", 1'b1);
      send_text("==", 1'b1);
      send_text("/", 1'b1);
      // comment still open at end of text: eof only
      send_text("//c", 1'b1);
      send_text(" ", 1'b1);
   endtask

   // receiver holds off while short tokens keep coming, so the queue fills and req stalls
   task automatic test_backpressure();
      sender_gaps_on   = 1'b0;
      hold_off_request = 1'b1;
      repeat (6) send_text("x1=(y+2)*z;\n", 1'b0);
      send_text("q", 1'b1);
      sender_gaps_on = 1'b1;
   endtask

   // random source text with stretches of gaps and stalls switched on and off
   task automatic test_random_text();
      int unsigned first;
      first = counted_bytes;
      while (counted_bytes - first < RANDOM_ITEMS) begin
         if ($urandom_range(0, 29) == 0) begin
            sender_gaps_on = ($urandom_range(0, 1) == 1);
         end
         if ($urandom_range(0, 29) == 0) begin
            receiver_stalls_on = ($urandom_range(0, 1) == 1);
         end
         send_fragment();
      end
      send_text(" ", 1'b1);
   endtask

   initial begin
      restart_text();
      have_held = 1'b0;
      // synchronous reset, released on a falling edge
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_keywords();
      test_operators();
      test_odd_bytes();
      test_backpressure();
      test_random_text();
      stop_sending();

      // wait for every predicted token, then drain for strays
      while (expected_tokens.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("source_tokenizer_unit_tb: PASS");
      end else begin
         $display("source_tokenizer_unit_tb: FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/stok_pkg.sv
sv/stok_front.sv
sv/stok_queue.sv
sv/stok_back.sv
sv/source_tokenizer_unit.sv
dv/source_tokenizer_unit_tb.sv
